[design/deq_pkg.sv]
// Package for the double-ended queue engine: sizes, request and status codes,
// and the command and status structs passed between the controller and the datapath.
// No dependencies; every other design file refers to it by scoped names.
package deq_pkg;

	// Store geometry.
	localparam int DEPTH     = 16;
	localparam int ITEM_BITS = 32;
	localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int SUM_W     = PTR_W + 1;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [ITEM_BITS-1:0] item_t;
	typedef logic [ACT_W-1:0]     action_t;
	typedef logic [STAT_W-1:0]    status_t;

	// Request codes.
	localparam action_t ACT_PUSH_FRONT = 3'd0;
	localparam action_t ACT_PUSH_BACK  = 3'd1;
	localparam action_t ACT_POP_FRONT  = 3'd2;
	localparam action_t ACT_POP_BACK   = 3'd3;
	localparam action_t ACT_PEEK_FRONT = 3'd4;
	localparam action_t ACT_PEEK_BACK  = 3'd5;
	localparam action_t ACT_SIZE       = 3'd6;

	// Response status codes.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// Command from the controller to the datapath for the beat being accepted.
	typedef struct packed {
		logic    accept;   // a request beat is taken at this edge
		logic    wr;       // store the request item
		logic    rd;       // read an entry for the response
		logic    at_back;  // operate on the back end rather than the front
		logic    remove;   // a read that also removes the entry
		status_t status;   // status reported for this request
	} cmd_t;

	// Queue condition reported by the datapath.
	typedef struct packed {
		logic empty;
		logic full;
	} dp_status_t;

endpackage

[design/deq_if.sv]
// Valid/ready channel interfaces for the request and response beats.
// Depends on deq_pkg for the field types.
interface deq_req_if;
	logic              valid;
	logic              ready;
	deq_pkg::action_t  action;
	deq_pkg::item_t    item;

	modport source (output valid, output action, output item, input ready);
	modport sink   (input valid, input action, input item, output ready);
endinterface

interface deq_rsp_if;
	logic              valid;
	logic              ready;
	deq_pkg::status_t  status;
	deq_pkg::item_t    result_item;
	deq_pkg::cnt_t     occupancy;

	modport source (output valid, output status, output result_item, output occupancy,
		input ready);
	modport sink   (input valid, input status, input result_item, input occupancy,
		output ready);
endinterface

[design/deq_ctrl.sv]
// Controller of the double-ended queue engine: handshake state machine and
// request decoding into datapath commands. Depends on deq_pkg.
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  deq_pkg::action_t    req_action,
	input  logic                rsp_ready,
	input  deq_pkg::dp_status_t dp_status,
	output logic                req_ready,
	output logic                rsp_valid,
	output deq_pkg::cmd_t       cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic accept;

	// A new beat is taken when no response is held, or when the held one leaves now.
	assign req_ready = (state_q == ST_IDLE) || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == ST_RESP);

	// The state records whether a response beat is on offer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= ST_RESP;
		end else if (rsp_ready) begin
			state_q <= ST_IDLE;
		end
	end

	// Decode the request against the current queue condition.
	always_comb begin
		cmd         = '0;
		cmd.accept  = accept;
		cmd.status  = deq_pkg::STATUS_OK;
		case (req_action)
			deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
				cmd.at_back = (req_action == deq_pkg::ACT_PUSH_BACK);
				if (dp_status.full) begin
					cmd.status = deq_pkg::STATUS_FULL;
				end else begin
					cmd.wr = accept;
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK,
			deq_pkg::ACT_PEEK_FRONT, deq_pkg::ACT_PEEK_BACK: begin
				cmd.at_back = (req_action == deq_pkg::ACT_POP_BACK) ||
					(req_action == deq_pkg::ACT_PEEK_BACK);
				if (dp_status.empty) begin
					cmd.status = deq_pkg::STATUS_EMPTY;
				end else begin
					cmd.rd     = accept;
					cmd.remove = accept && ((req_action == deq_pkg::ACT_POP_FRONT) ||
						(req_action == deq_pkg::ACT_POP_BACK));
				end
			end
			default: begin
				// Size requests and unused codes leave the queue as it is.
				cmd.status = deq_pkg::STATUS_OK;
			end
		endcase
	end

endmodule

[design/deq_datapath.sv]
// Datapath of the double-ended queue engine: ring store, head pointer,
// item count and response registers. Depends on deq_pkg.
module deq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::cmd_t       cmd,
	input  deq_pkg::item_t      item,
	output deq_pkg::dp_status_t dp_status,
	output deq_pkg::status_t    status,
	output deq_pkg::item_t      result_item,
	output deq_pkg::cnt_t       occupancy
);

	deq_pkg::item_t   mem [deq_pkg::DEPTH];
	deq_pkg::ptr_t    head_q;
	deq_pkg::cnt_t    count_q;
	deq_pkg::item_t   rd_q;
	logic             hit_q;
	deq_pkg::status_t status_q;

	deq_pkg::ptr_t head_prev;
	deq_pkg::ptr_t head_next;
	deq_pkg::sum_t tail_sum;
	deq_pkg::sum_t last_sum;
	deq_pkg::ptr_t tail_idx;
	deq_pkg::ptr_t last_idx;
	deq_pkg::ptr_t wr_addr;
	deq_pkg::ptr_t rd_addr;

	// Ring positions around the head, wrapped by one compare each.
	assign head_prev = (head_q == '0) ? deq_pkg::PTR_W'(deq_pkg::DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Free slot behind the back item and the back item itself.
	assign tail_sum = {1'b0, head_q} + deq_pkg::SUM_W'(count_q);
	assign last_sum = tail_sum - 1'b1;
	assign tail_idx = (tail_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) ?
		deq_pkg::PTR_W'(tail_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH)) :
		deq_pkg::PTR_W'(tail_sum);
	assign last_idx = (last_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) ?
		deq_pkg::PTR_W'(last_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH)) :
		deq_pkg::PTR_W'(last_sum);

	assign wr_addr = cmd.at_back ? tail_idx : head_prev;
	assign rd_addr = cmd.at_back ? last_idx : head_q;

	assign dp_status.empty = (count_q == '0);
	assign dp_status.full  = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));

	// Ring store write port.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= item;
		end
	end

	// Ring store read port with registered data.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Head pointer and item count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.wr) begin
			count_q <= count_q + 1'b1;
			if (!cmd.at_back) begin
				head_q <= head_prev;
			end
		end else if (cmd.remove) begin
			count_q <= count_q - 1'b1;
			if (!cmd.at_back) begin
				head_q <= head_next;
			end
		end
	end

	// Response fields captured with each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			status_q <= deq_pkg::STATUS_OK;
		end else if (cmd.accept) begin
			hit_q    <= cmd.rd;
			status_q <= cmd.status;
		end
	end

	assign status      = status_q;
	assign result_item = hit_q ? rd_q : '0;
	assign occupancy   = count_q;

endmodule

[design/double_ended_queue_engine_core.sv]
// Double-ended queue engine, top level. Each request beat on req pushes an item at
// the front or back, pops or peeks at either end, or asks for the size, and yields
// exactly one response beat on rsp with a status, the item read (zero otherwise) and
// the number of items held afterwards. The response appears in the cycle after the
// request is taken and is held until accepted; a new request is taken in the same
// cycle the pending response leaves, so the engine sustains one request per cycle
// while rsp.ready stays high, and otherwise one request per response handshake. The
// single registered read port of the ring store supplies the item read. The ring
// store holds deq_pkg::DEPTH items; a push onto a full store is dropped with status full.
// Depends on deq_pkg, deq_if, deq_ctrl and deq_datapath.
module double_ended_queue_engine_core (
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	deq_pkg::cmd_t       cmd;
	deq_pkg::dp_status_t dp_status;

	// Handshake control and request decoding.
	deq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.rsp_ready  (rsp.ready),
		.dp_status  (dp_status),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.cmd        (cmd)
	);

	// Ring store and pointers.
	deq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (req.item),
		.dp_status   (dp_status),
		.status      (rsp.status),
		.result_item (rsp.result_item),
		.occupancy   (rsp.occupancy)
	);

`ifndef SYNTHESIS
	// An accepted request beat always produces a response beat in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("response beat missing after accepted request");

	// A full report only occurs with the store full.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == deq_pkg::STATUS_FULL) |->
		(rsp.occupancy == deq_pkg::CNT_W'(deq_pkg::DEPTH)))
		else $error("full status with spare room in the store");

	// An empty report only occurs with nothing held, and carries a zero item.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == deq_pkg::STATUS_EMPTY) |->
		(rsp.occupancy == '0 && rsp.result_item == '0))
		else $error("empty status with items held");

	// The count never exceeds the store depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.occupancy <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("occupancy beyond store depth");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for double_ended_queue_engine_core: a shadow deque predicts every
// response beat, and the responses are compared field by field in order of arrival.
// Depends on deq_pkg, the deq_req_if and deq_rsp_if interfaces and the design files.
module tb;
	import deq_pkg::*;

	// Spare request code: the engine answers it as a size request.
	localparam action_t ACT_SPARE   = 3'd7;
	localparam int      HOLD_CYCLES = 60;
	localparam int      STALL_LIMIT = 2000;
	localparam int      PHASE_ITEMS = 400;
	localparam int      CHUNK_ITEMS = 25;
	localparam int      PRINT_LIMIT = 100;

	typedef struct packed {
		status_t status;
		item_t   result_item;
		cnt_t    occupancy;
	} reply_t;

	typedef struct {
		action_t     action;
		item_t       item;
		int unsigned send_idle;
		int unsigned recv_idle;
		bit          drain_first;
		bit          hold_rsp;
	} request_beat_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_engine_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	request_beat_t queued_requests[$];
	reply_t        pending_replies[$];

	// Shadow copy of the engine's queue.
	item_t shadow_ring [DEPTH];
	ptr_t  shadow_head  = '0;
	cnt_t  shadow_count = '0;

	int unsigned accepted_reqs;
	int unsigned checked_rsps;
	int unsigned fail_count;
	int unsigned idle_cycles;
	int unsigned hold_left;
	int unsigned rsp_idle_pct;
	int unsigned cur_send_idle;
	int unsigned cur_recv_idle;
	logic        hold_trigger = 1'b0;

	// Free-running clock; the driver and the monitor set their outputs during reset.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset is held low from time zero and released at a rising edge.
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one request to the shadow deque and returns the response the engine owes.
	function automatic reply_t deque_reply(action_t act, item_t itm);
		reply_t r;
		int     slot;
		r.status      = STATUS_OK;
		r.result_item = '0;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (shadow_count == cnt_t'(DEPTH)) begin
					r.status = STATUS_FULL;
				end else if (act == ACT_PUSH_FRONT) begin
					shadow_head = ptr_t'((int'(shadow_head) + DEPTH - 1) % DEPTH);
					shadow_ring[shadow_head] = itm;
					shadow_count++;
				end else begin
					slot = (int'(shadow_head) + int'(shadow_count)) % DEPTH;
					shadow_ring[slot] = itm;
					shadow_count++;
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
				if (shadow_count == '0) begin
					r.status = STATUS_EMPTY;
				end else if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) begin
					r.result_item = shadow_ring[shadow_head];
					if (act == ACT_POP_FRONT) begin
						shadow_head = ptr_t'((int'(shadow_head) + 1) % DEPTH);
						shadow_count--;
					end
				end else begin
					slot = (int'(shadow_head) + int'(shadow_count) - 1) % DEPTH;
					r.result_item = shadow_ring[slot];
					if (act == ACT_POP_BACK)
						shadow_count--;
				end
			end
			// Size requests and the spare code leave the queue alone.
			default: ;
		endcase
		r.occupancy = shadow_count;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		if (fail_count < PRINT_LIMIT)
			$display("[%0t] response %0d: %s", $realtime, checked_rsps, what);
		fail_count++;
	endtask

	task automatic check_reply();
		reply_t want;
		if (pending_replies.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, status %0d item %h occupancy %0d",
				rsp_ch.status, rsp_ch.result_item, rsp_ch.occupancy));
		end else begin
			want = pending_replies.pop_front();
			if (rsp_ch.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d",
					rsp_ch.status, want.status));
			if (rsp_ch.result_item !== want.result_item)
				report_mismatch($sformatf("result_item %h, expected %h",
					rsp_ch.result_item, want.result_item));
			if (rsp_ch.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, expected %0d",
					rsp_ch.occupancy, want.occupancy));
		end
	endtask

	task automatic queue_request(action_t act, item_t itm, bit drain = 1'b0,
		bit hold = 1'b0);
		request_beat_t beat;
		beat.action      = act;
		beat.item        = itm;
		beat.send_idle   = cur_send_idle;
		beat.recv_idle   = cur_recv_idle;
		beat.drain_first = drain;
		beat.hold_rsp    = hold;
		queued_requests.push_back(beat);
	endtask

	// Request driver: the accepted beat goes through the shadow deque, then the next is offered.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic        offer;
		logic        trigger;
		int unsigned accepted_next;
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.action <= ACT_SIZE;
			req_ch.item   <= '0;
			hold_trigger  <= 1'b0;
			rsp_idle_pct  <= 0;
			accepted_reqs <= 0;
			shadow_head   = '0;
			shadow_count  = '0;
		end else begin
			offer         = req_ch.valid;
			trigger       = 1'b0;
			accepted_next = accepted_reqs;
			if (req_ch.valid && req_ch.ready) begin
				pending_replies.push_back(deque_reply(req_ch.action, req_ch.item));
				trigger = queued_requests[0].hold_rsp;
				void'(queued_requests.pop_front());
				accepted_next++;
				offer = 1'b0;
			end
			// A beat marked to drain waits until every response has been checked.
			if (!offer && queued_requests.size() > 0) begin
				if (queued_requests[0].drain_first)
					offer = (accepted_next == checked_rsps);
				else
					offer = ($urandom_range(99) >= queued_requests[0].send_idle);
			end
			req_ch.valid <= offer;
			if (offer) begin
				req_ch.action <= queued_requests[0].action;
				req_ch.item   <= queued_requests[0].item;
				rsp_idle_pct  <= queued_requests[0].recv_idle;
			end
			hold_trigger  <= trigger;
			accepted_reqs <= accepted_next;
		end
	end

	// Response monitor: checks each beat and decides readiness, with long hold-offs on request.
	always @(posedge clk or negedge arst_n) begin : collect_replies
		int unsigned hold_next;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			checked_rsps <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_reply();
				checked_rsps <= checked_rsps + 1;
			end
			if (hold_trigger)
				hold_next = HOLD_CYCLES;
			else if (hold_left > 0)
				hold_next = hold_left - 1;
			else
				hold_next = 0;
			hold_left    <= hold_next;
			rsp_ch.ready <= (hold_next == 0) && ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Watchdog: too long without a beat on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus, then the wait for the last response and the verdict.
	initial begin : stimulus
		int unsigned push_pct;
		int unsigned pick;
		item_t       handle;
		action_t     act;
		cur_send_idle = 27;
		cur_recv_idle = 84;
		push_pct      = 50;

		// Reads and size requests on the empty queue, and the spare code.
		queue_request(ACT_PEEK_FRONT, '0);
		queue_request(ACT_PEEK_BACK, '1);
		queue_request(ACT_POP_FRONT, '0);
		queue_request(ACT_POP_BACK, '1);
		queue_request(ACT_SIZE, '0);
		queue_request(ACT_SPARE, 32'h1234_5678);
		// Fill from both ends, with all-ones and all-zero handles among them.
		for (int n = 0; n < DEPTH; n++) begin
			if (n == 0)
				handle = '1;
			else if (n == 1)
				handle = '0;
			else
				handle = item_t'(32'hA5C3_0000 ^ (n * 32'h0101_0101));
			queue_request(n[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, handle);
		end
		// Pushes onto the full queue are dropped.
		queue_request(ACT_PUSH_BACK, 32'hDEAD_0001);
		queue_request(ACT_PUSH_FRONT, 32'hDEAD_0002);
		queue_request(ACT_PEEK_FRONT, '0);
		queue_request(ACT_PEEK_BACK, '0);
		queue_request(ACT_POP_BACK, '0);
		queue_request(ACT_POP_FRONT, '0);

		// Random traffic in three idling phases; push-heavy and pop-heavy stretches
		// walk the occupancy between empty and full.
		for (int ph = 0; ph < 3; ph++) begin
			cur_send_idle = (ph == 0) ? 27 : (ph == 1) ? 84 : 0;
			cur_recv_idle = (ph == 0) ? 84 : (ph == 1) ? 27 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % CHUNK_ITEMS == 0) begin
					case ($urandom_range(4))
						0: push_pct = 3;
						1: push_pct = 30;
						2: push_pct = 50;
						3: push_pct = 70;
						default: push_pct = 97;
					endcase
				end
				if ($urandom_range(99) < push_pct) begin
					act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
					case ($urandom_range(7))
						0: handle = '0;
						1: handle = '1;
						default: handle = item_t'($urandom);
					endcase
				end else begin
					// The handle is ignored here but still toggles on the bus.
					handle = item_t'($urandom);
					pick   = $urandom_range(15);
					if (pick < 4)
						act = ACT_POP_FRONT;
					else if (pick < 8)
						act = ACT_POP_BACK;
					else if (pick < 11)
						act = ACT_PEEK_FRONT;
					else if (pick < 14)
						act = ACT_PEEK_BACK;
					else if (pick == 14)
						act = ACT_SIZE;
					else
						act = ACT_SPARE;
				end
				queue_request(act, handle, n == 0, (n == PHASE_ITEMS / 2) && (ph != 1));
			end
		end

		while (queued_requests.size() > 0 || req_ch.valid || accepted_reqs != checked_rsps)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
